// File: sv/positional_list_engine_top_macros.svh
// Assertion helpers used by the checker file
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, gated by reset
`define PLE_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("positional list engine: implication check failed");

// Next-cycle implication, gated by reset
`define PLE_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("positional list engine: next-cycle check failed");

`endif

// File: sv/plist_pkg.sv
package plist_pkg;

   localparam int OP_W       = 3;
   localparam int POSITION_W = 8;
   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 5;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_ROTATE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] last_idx;
   } cell_ctrl_type;

endpackage

// File: sv/plist_if.sv
interface plist_req_if import plist_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic signed [POSITION_W-1:0] position;
   logic [VALUE_W-1:0]           value_in;

   modport source (output valid, output op, output position, output value_in, input ready);
   modport sink   (input valid, input op, input position, input value_in, output ready);
endinterface

interface plist_rsp_if import plist_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  value_out;
   logic                element_valid;
   logic                last;
   logic [LENGTH_W-1:0] length;

   modport source (output valid, output status, output value_out, output element_valid,
                   output last, output length, input ready);
   modport sink   (input valid, input status, input value_out, input element_valid,
                   input last, input length, output ready);
endinterface

// File: sv/plist_cell.sv
module plist_cell import plist_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] prev_q,
   input  logic [DATA_WIDTH-1:0] next_q,
   input  logic [DATA_WIDTH-1:0] head_q,
   input  logic [DATA_WIDTH-1:0] ins_data,
   output logic [DATA_WIDTH-1:0] data_q
);

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.cmd)
         CMD_INSERT: begin
            if (IDX > ctrl.pos) begin
               data_in = prev_q;
            end else if (IDX == ctrl.pos) begin
               data_in = ins_data;
            end
         end
         CMD_DELETE: begin
            if (IDX >= ctrl.pos) begin
               data_in = next_q;
            end
         end
         CMD_ROTATE: begin
            if (IDX < ctrl.last_idx) begin
               data_in = next_q;
            end else if (IDX == ctrl.last_idx) begin
               data_in = head_q;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// File: sv/plist_ctrl.sv
module plist_ctrl import plist_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   plist_req_if.sink             req_chan,
   plist_rsp_if.source           rsp_chan,
   input  logic [DATA_WIDTH-1:0] head_data,
   output cell_ctrl_type         ctrl,
   output logic [DATA_WIDTH-1:0] ins_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       dump_idx_ff, dump_idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  value_out_ff, value_out_in;
   logic                elem_ff, elem_in;
   logic                last_ff, last_in;
   logic [LENGTH_W-1:0] length_ff, length_in;

   logic             out_free;
   logic             accept;
   logic             neg;
   logic             empty;
   logic             full;
   logic             dump_last;
   logic [POS_W-1:0] praw;
   logic [POS_W-1:0] cnt;
   logic [POS_W-1:0] ins_pos;
   logic [POS_W-1:0] del_pos;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign neg   = req_chan.position[POSITION_W-1];
   assign praw  = req_chan.position[POS_W-1:0];
   assign cnt   = POS_W'(count_ff);
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CAPACITY));
   assign dump_last = (dump_idx_ff == count_ff - 1'b1);
   assign ins_data  = DATA_WIDTH'(req_chan.value_in);

   always_comb begin
      ins_pos = cnt;
      if (req_chan.op == OP_INS_FRONT) begin
         ins_pos = '0;
      end else if (req_chan.op == OP_INS_AT && praw < cnt) begin
         ins_pos = praw;
      end
      del_pos = praw;
      if (req_chan.op == OP_DEL_FRONT) begin
         del_pos = '0;
      end else if (req_chan.op == OP_DEL_BACK) begin
         del_pos = cnt - 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      value_out_in = value_out_ff;
      elem_in      = elem_ff;
      last_in      = last_ff;
      length_in    = length_ff;
      ctrl         = '{cmd: CMD_HOLD, pos: '0, last_idx: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in    = STAT_OK;
               value_out_in = '0;
               elem_in      = 1'b0;
               last_in      = 1'b1;
               out_valid_in = 1'b1;
               case (req_chan.op) inside
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                     if (req_chan.op == OP_INS_AT && neg) begin
                        status_in = STAT_BADPOS;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ctrl.cmd = CMD_INSERT;
                        ctrl.pos = ins_pos;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                     if (req_chan.op == OP_DEL_AT && neg) begin
                        status_in = STAT_BADPOS;
                     end else if (empty) begin
                        status_in = STAT_EMPTY;
                     end else if (req_chan.op == OP_DEL_AT && praw >= cnt) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        ctrl.cmd = CMD_DELETE;
                        ctrl.pos = del_pos;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        out_valid_in = 1'b0;
                        dump_idx_in  = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: status_in = STAT_OK;
               endcase
               length_in = LENGTH_W'(count_in);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               status_in     = STAT_OK;
               value_out_in  = VALUE_W'(head_data);
               elem_in       = 1'b1;
               last_in       = dump_last;
               length_in     = LENGTH_W'(count_ff);
               out_valid_in  = 1'b1;
               ctrl.cmd      = CMD_ROTATE;
               ctrl.last_idx = cnt - 1'b1;
               dump_idx_in   = dump_idx_ff + 1'b1;
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      value_out_ff <= value_out_in;
      elem_ff      <= elem_in;
      last_ff      <= last_in;
      length_ff    <= length_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.value_out     = value_out_ff;
   assign rsp_chan.element_valid = elem_ff;
   assign rsp_chan.last          = last_ff;
   assign rsp_chan.length        = length_ff;

endmodule

// File: sv/positional_list_engine_top.sv
// Bounded ordered list of up to CAPACITY values held in a row of cells, front first.
// Each element sits in its own cell; an insert or delete shifts the affected cells by
// one place at once, and the next item is taken as soon as the result register is
// free. A dump of n elements first accepts the request, then gives one element per
// cycle while the result register is free, read from the front cell while the chain
// rotates by one place, which leaves the list in its original order at the end.
// An empty dump, like every other operation, gives a single result. No item is taken
// while a dump is streaming. There is no clearing pass after reset; cells beyond the
// current length are never shown.
module positional_list_engine_top import plist_pkg::*; #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   plist_req_if.sink   req_chan,
   plist_rsp_if.source rsp_chan
);

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] ins_data;
   logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

   plist_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .head_data (cell_q[0]),
      .ctrl      (ctrl),
      .ins_data  (ins_data)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_q;
      logic [DATA_WIDTH-1:0] next_q;

      if (g == 0) begin : g_first
         assign prev_q = '0;
      end else begin : g_prev
         assign prev_q = cell_q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_end
         assign next_q = '0;
      end else begin : g_next
         assign next_q = cell_q[g+1];
      end

      plist_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (g)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .prev_q   (prev_q),
         .next_q   (next_q),
         .head_q   (cell_q[0]),
         .ins_data (ins_data),
         .data_q   (cell_q[g])
      );
   end

endmodule

// File: sv/plist_checker.sv
`include "positional_list_engine_top_macros.svh"

module plist_checker import plist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_value_out,
   input logic                rsp_element_valid,
   input logic                rsp_last,
   input logic [LENGTH_W-1:0] rsp_length
);

   `PLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_value_out) && $stable(rsp_element_valid) && $stable(rsp_last) && $stable(rsp_length))
   `PLE_ASSERT_IMPLY(a_plain_result, clock, reset, rsp_valid && !rsp_element_valid, rsp_last && rsp_value_out == '0)
   `PLE_ASSERT_IMPLY(a_full_length, clock, reset, rsp_valid && rsp_status == STAT_FULL, rsp_length == LENGTH_W'(CAPACITY) && !rsp_element_valid)
   `PLE_ASSERT_IMPLY(a_empty_result, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, rsp_length == '0 && !rsp_element_valid)

endmodule

bind positional_list_engine_top plist_checker #(
   .CAPACITY (CAPACITY)
) u_plist_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_value_out     (rsp_chan.value_out),
   .rsp_element_valid (rsp_chan.element_valid),
   .rsp_last          (rsp_chan.last),
   .rsp_length        (rsp_chan.length)
);
